@@ rtl/chained_hash_table_unit_assert.svh @@
`ifndef CHAINED_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_UNIT_ASSERT_SVH

// Checks on i_clk, held off while i_rst_n is low.

`define CHU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CHU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define CHU_ASSERT_ALW(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

@@ rtl/chu_pkg.sv @@
package chu_pkg;

    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    localparam int OPC_W  = 2;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPC_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // key mod BUCKETS is reduced one hex digit per cycle, MSB first
    localparam int DIGIT_W    = 4;
    localparam int KEY_DIGITS = KEY_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(KEY_DIGITS);

    typedef struct packed {
        logic load;
        logic clr;
        logic mod_step;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/chu_if.sv @@
interface chu_req_if;
    logic                       valid;
    logic                       ready;
    logic [chu_pkg::OPC_W-1:0]  opcode;
    logic [chu_pkg::KEY_W-1:0]  key;
    logic [chu_pkg::VAL_W-1:0]  value;

    modport source (output valid, opcode, key, value, input ready);
    modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface chu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [chu_pkg::STAT_W-1:0] status;
    logic [chu_pkg::VAL_W-1:0]  found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

@@ rtl/chu_ctrl.sv @@
module chu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  chu_pkg::t_sts i_sts,
    output chu_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_DECIDE
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_state <= S_MOD;
                        r_ready <= 1'b0;
                    end
                end
                S_MOD: begin
                    if (i_sts.mod_last) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_ready <= 1'b0;
                end
            endcase
        end
    end

    assign o_ready        = r_ready;
    assign o_cmd.load     = r_ready && i_valid;
    assign o_cmd.clr      = (r_state == S_CLEAR);
    assign o_cmd.mod_step = (r_state == S_MOD);
    assign o_cmd.rd       = (r_state == S_READ);
    assign o_cmd.commit   = (r_state == S_DECIDE) && i_sts.out_free;

endmodule

@@ rtl/chu_dp.sv @@
module chu_dp #(
    parameter int BUCKETS = chu_pkg::BUCKETS_DEF,
    parameter int WAYS    = chu_pkg::WAYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  chu_pkg::t_cmd              i_cmd,
    output chu_pkg::t_sts              o_sts,
    input  logic [chu_pkg::OPC_W-1:0]  i_opcode,
    input  logic [chu_pkg::KEY_W-1:0]  i_key,
    input  logic [chu_pkg::VAL_W-1:0]  i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [chu_pkg::STAT_W-1:0] o_status,
    output logic [chu_pkg::VAL_W-1:0]  o_found_value
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int TW    = BKT_W + chu_pkg::DIGIT_W;
    localparam int RADIX = 1 << chu_pkg::DIGIT_W;
    localparam int KW    = chu_pkg::KEY_W;
    localparam int VW    = chu_pkg::VAL_W;

    // bucket rows
    logic [WAYS-1:0]         mem_vld [BUCKETS];
    logic [WAYS-1:0][KW-1:0] mem_key [BUCKETS];
    logic [WAYS-1:0][VW-1:0] mem_val [BUCKETS];

    logic [chu_pkg::OPC_W-1:0]     r_op;
    logic [KW-1:0]                 r_key;
    logic [VW-1:0]                 r_value;
    logic [KW-1:0]                 r_kshift;
    logic [chu_pkg::DIG_CNT_W-1:0] r_dig;
    logic [BKT_W-1:0]              r_rem;
    logic [BKT_W-1:0]              r_clr_idx;

    logic [WAYS-1:0]         r_rd_vld;
    logic [WAYS-1:0][KW-1:0] r_rd_key;
    logic [WAYS-1:0][VW-1:0] r_rd_val;

    logic                       r_out_valid;
    logic [chu_pkg::STAT_W-1:0] r_out_status;
    logic [VW-1:0]              r_out_found;

    logic [TW-1:0]              mod_t;
    logic [TW-1:0]              n_rem;
    logic [WAYS-1:0]            hitv;
    logic [WAYS-1:0]            freev;
    logic [WAYS-1:0]            lowfree;
    logic                       any_hit;
    logic                       any_free;
    logic [VW-1:0]              hit_val;
    logic [WAYS-1:0]            n_vld;
    logic [WAYS-1:0][KW-1:0]    n_key;
    logic [WAYS-1:0][VW-1:0]    n_val;
    logic [chu_pkg::STAT_W-1:0] n_status;
    logic [VW-1:0]              n_found;

    // one remainder digit: (rem*16 + digit) mod BUCKETS
    always_comb begin
        mod_t = {r_rem, r_kshift[KW-1 -: chu_pkg::DIGIT_W]};
        n_rem = mod_t;
        for (int k = 1; k < RADIX; k++) begin
            if (mod_t >= TW'(k * BUCKETS)) begin
                n_rem = mod_t - TW'(k * BUCKETS);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hitv[w] = r_rd_vld[w] && (r_rd_key[w] == r_key);
        end
        freev    = ~r_rd_vld;
        lowfree  = freev & (~freev + WAYS'(1));
        any_hit  = |hitv;
        any_free = |freev;
        hit_val  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hitv[w]) begin
                hit_val = hit_val | r_rd_val[w];
            end
        end
    end

    always_comb begin
        n_vld    = r_rd_vld;
        n_key    = r_rd_key;
        n_val    = r_rd_val;
        n_status = chu_pkg::ST_OK;
        n_found  = '0;
        unique case (r_op)
            chu_pkg::OP_INSERT: begin
                if (any_hit) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (hitv[w]) begin
                            n_val[w] = r_value;
                        end
                    end
                end else if (any_free) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (lowfree[w]) begin
                            n_vld[w] = 1'b1;
                            n_key[w] = r_key;
                            n_val[w] = r_value;
                        end
                    end
                end else begin
                    n_status = chu_pkg::ST_FULL;
                end
            end
            chu_pkg::OP_SEARCH: begin
                if (any_hit) begin
                    n_found = hit_val;
                end else begin
                    n_status = chu_pkg::ST_MISSING;
                end
            end
            chu_pkg::OP_REMOVE: begin
                n_vld = r_rd_vld & ~hitv;
                if (!any_hit) begin
                    n_status = chu_pkg::ST_MISSING;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig     <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + BKT_W'(1);
            end
            if (i_cmd.load) begin
                r_dig <= '0;
            end else if (i_cmd.mod_step) begin
                r_dig <= r_dig + chu_pkg::DIG_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_key    <= i_key;
            r_value  <= i_value;
            r_kshift <= i_key;
            r_rem    <= '0;
        end else if (i_cmd.mod_step) begin
            r_kshift <= r_kshift << chu_pkg::DIGIT_W;
            r_rem    <= n_rem[BKT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem_vld[r_clr_idx] <= '0;
        end else if (i_cmd.commit) begin
            mem_vld[r_rem] <= n_vld;
            mem_key[r_rem] <= n_key;
            mem_val[r_rem] <= n_val;
        end
        if (i_cmd.rd) begin
            r_rd_vld <= mem_vld[r_rem];
            r_rd_key <= mem_key[r_rem];
            r_rd_val <= mem_val[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_found  <= n_found;
        end
    end

    assign o_sts.clr_last = (r_clr_idx == BKT_W'(BUCKETS - 1));
    assign o_sts.mod_last = (r_dig == chu_pkg::DIG_CNT_W'(chu_pkg::KEY_DIGITS - 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;

endmodule

@@ rtl/chained_hash_table_unit.sv @@
// channel | dir | words carried             | handshake
// i_req   | in  | opcode, key, value        | valid/ready, taken when both high
// o_rsp   | out | status, found_value       | valid/ready, taken when both high
//
// One request at a time (accept, key mod BUCKETS one hex digit a cycle, a
// bucket row read, then compare and write-back); the result is registered at
// the compare and write-back step.
// The next request is taken the cycle after the result is registered.
// After reset a clearing pass sweeps the valid rows, with ready low.
// A stalled result holds in the output register; the block then finishes the
// next request up to the compare step and waits there.

`include "chained_hash_table_unit_assert.svh"

module chained_hash_table_unit #(
    parameter int BUCKETS = chu_pkg::BUCKETS_DEF,
    parameter int WAYS    = chu_pkg::WAYS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chu_req_if.sink   i_req,
    chu_rsp_if.source o_rsp
);

    chu_pkg::t_cmd cmd;
    chu_pkg::t_sts sts;

    chu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    chu_dp #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_req.opcode),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_found_value (o_rsp.found_value)
    );

    `CHU_ASSERT_IMP(a_commit_free, cmd.commit, !o_rsp.valid || o_rsp.ready, "result overwritten")
    `CHU_ASSERT_NXT(a_commit_out, cmd.commit, o_rsp.valid, "result not presented")
    `CHU_ASSERT_IMP(a_one_item, i_req.ready, !cmd.mod_step && !cmd.rd && !cmd.commit, "overlap")
    `CHU_ASSERT_ALW(a_one_cmd, $onehot0({cmd.clr, cmd.mod_step, cmd.rd, cmd.commit}), "cmd clash")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int N_BUCKETS  = chu_pkg::BUCKETS_DEF;
    localparam int N_WAYS     = chu_pkg::WAYS_DEF;
    localparam int N_SLOTS    = N_BUCKETS * N_WAYS;
    localparam int PHASE_REQS = 160;
    localparam int POOL_KEYS  = 40;
    localparam int LONG_HOLD  = 250;
    localparam int HOLD_AT    = 400;
    localparam int IDLE_LIMIT = 3000;

    // opcode with no operation behind it
    localparam logic [chu_pkg::OPC_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [chu_pkg::OPC_W-1:0] op;
        logic [chu_pkg::KEY_W-1:0] key;
        logic [chu_pkg::VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [chu_pkg::STAT_W-1:0] status;
        logic [chu_pkg::VAL_W-1:0]  found_value;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    chu_req_if req_bus ();
    chu_rsp_if rsp_bus ();

    chained_hash_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model of the table contents
    logic                      tbl_valid [N_SLOTS];
    logic [chu_pkg::KEY_W-1:0] tbl_key   [N_SLOTS];
    logic [chu_pkg::VAL_W-1:0] tbl_value [N_SLOTS];

    t_req                      request_q [$];
    t_rsp                      answer_q  [$];
    logic [chu_pkg::KEY_W-1:0] key_pool  [POOL_KEYS];

    int send_idle_pct;
    int recv_idle_pct;
    int n_answers;
    int n_mismatch;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    function automatic t_rsp hash_table_op(t_req r);
        t_rsp res;
        int   base;
        int   hit;
        int   w;
        bit   placed;
        res.status      = chu_pkg::ST_OK;
        res.found_value = '0;
        base = int'(r.key % N_BUCKETS) * N_WAYS;
        hit  = -1;
        for (w = 0; w < N_WAYS; w++) begin
            if (hit < 0 && tbl_valid[base + w] && tbl_key[base + w] == r.key) begin
                hit = base + w;
            end
        end
        case (r.op)
            chu_pkg::OP_INSERT: begin
                if (hit >= 0) begin
                    tbl_value[hit] = r.value;
                end else begin
                    placed = 1'b0;
                    for (w = 0; w < N_WAYS; w++) begin
                        if (!placed && !tbl_valid[base + w]) begin
                            tbl_valid[base + w] = 1'b1;
                            tbl_key[base + w]   = r.key;
                            tbl_value[base + w] = r.value;
                            placed = 1'b1;
                        end
                    end
                    if (!placed) begin
                        res.status = chu_pkg::ST_FULL;
                    end
                end
            end
            chu_pkg::OP_SEARCH: begin
                if (hit >= 0) begin
                    res.found_value = tbl_value[hit];
                end else begin
                    res.status = chu_pkg::ST_MISSING;
                end
            end
            chu_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                end else begin
                    res.status = chu_pkg::ST_MISSING;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_req(logic [chu_pkg::OPC_W-1:0] op, logic [chu_pkg::KEY_W-1:0] key,
                            logic [chu_pkg::VAL_W-1:0] value);
        t_req r;
        r.op    = op;
        r.key   = key;
        r.value = value;
        request_q = {request_q, r};
    endtask

    // mostly keys from a small pool crowded into a few buckets, so
    // replaces, hits, removes and full buckets all come up often
    function automatic t_req random_req();
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            r.op = chu_pkg::OP_INSERT;
        end else if (roll < 75) begin
            r.op = chu_pkg::OP_SEARCH;
        end else if (roll < 95) begin
            r.op = chu_pkg::OP_REMOVE;
        end else begin
            r.op = OP_NOP;
        end
        if ($urandom_range(0, 99) < 80) begin
            r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        end else begin
            r.key = $urandom();
        end
        r.value = $urandom();
        return r;
    endfunction

    always @(posedge i_clk) begin : req_drive
        t_req r;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                r.op    = req_bus.opcode;
                r.key   = req_bus.key;
                r.value = req_bus.value;
                answer_q = {answer_q, hash_table_op(r)};
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = request_q.pop_front();
                    req_bus.valid  <= 1'b1;
                    req_bus.opcode <= r.op;
                    req_bus.key    <= r.key;
                    req_bus.value  <= r.value;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                n_answers++;
                if (answer_q.size() == 0) begin
                    $error("unexpected result word: status %0d found_value %h",
                           rsp_bus.status, rsp_bus.found_value);
                    n_mismatch++;
                end else begin
                    want = answer_q.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        n_mismatch++;
                    end
                    if (rsp_bus.found_value !== want.found_value) begin
                        $error("found_value: expected %h, got %h",
                               want.found_value, rsp_bus.found_value);
                        n_mismatch++;
                    end
                end
            end
            // one long back-pressure stretch to fill the block up
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (!hold_done && n_answers >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        int ph;
        int k;
        i_rst_n        = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.opcode = '0;
        req_bus.key    = '0;
        req_bus.value  = '0;
        rsp_bus.ready  = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        n_answers      = 0;
        n_mismatch     = 0;
        idle_cycles    = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        for (k = 0; k < N_SLOTS; k++) begin
            tbl_valid[k] = 1'b0;
        end
        for (k = 0; k < POOL_KEYS; k++) begin
            key_pool[k] = {28'($urandom() >> 4), 4'($urandom_range(0, 5))};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 3; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
                push_req(chu_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
                push_req(chu_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
                push_req(chu_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
                // fill one bucket, overflow it, then free a middle way
                push_req(chu_pkg::OP_INSERT, 32'h0000_0005, 32'hA5A5_0001);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0015, 32'hA5A5_0002);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0025, 32'hA5A5_0003);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0035, 32'hA5A5_0004);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0045, 32'h5A5A_0005);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0045, 32'h0000_0000);
                push_req(chu_pkg::OP_REMOVE, 32'h0000_0025, 32'h0000_0000);
                push_req(chu_pkg::OP_INSERT, 32'h0000_0045, 32'h5A5A_0006);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0045, 32'h0000_0000);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0025, 32'h0000_0000);
                push_req(OP_NOP,             32'h0000_0000, 32'hFFFF_FFFF);
                push_req(chu_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
                push_req(chu_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
            end
            for (k = 0; k < PHASE_REQS; k++) begin
                request_q = {request_q, random_req()};
            end
            while (request_q.size() != 0 || req_bus.valid || answer_q.size() != 0) begin
                @(negedge i_clk);
            end
        end

        repeat (20) @(posedge i_clk);
        if (n_mismatch == 0 && answer_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
